// File: sv/rgb_box_downsampler_assert.svh
// ----------------------------------------------------------------------------
// rgb box downsampler assertion macros
// concurrent checks clocked on clk_i and disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef RGB_BOX_DOWNSAMPLER_ASSERT_SVH
`define RGB_BOX_DOWNSAMPLER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define RBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define RBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: sv/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types and constants of the rgb box downsampler
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int PIX_W         = 8;
  localparam int WIDTH_FIELD_W = 14;
  localparam int HEIGHT_W      = 16;
  localparam int FACTOR_W      = 6;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [WIDTH_FIELD_W-1:0] WIDTH_RST  = 14'd8192;
  localparam logic [HEIGHT_W-1:0]      HEIGHT_RST = 16'd1;
  localparam logic [FACTOR_W-1:0]      FACTOR_RST = 6'd2;

  // output queue between the averaging multipliers and the output port
  localparam int QDEPTH = 4;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_FACTOR = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } pix_t;

  // per-pixel block control, travels with the pixel into the accumulator
  typedef struct packed {
    logic first;
    logic emit;
    logic last;
  } blk_ctl_t;

  typedef struct packed {
    logic valid;
    logic last;
  } out_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             last;
  } avg_pix_t;

endpackage

// File: sv/rbd_recip.sv
// ----------------------------------------------------------------------------
// rbd_recip
// bit-serial unit that computes ceil(2^K / (f*f)) for the averaging multiply
// ----------------------------------------------------------------------------
module rbd_recip #(
  parameter int FEW = 6,
  parameter int NW  = 11,
  parameter int K   = 29
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [FEW-1:0] factor_i,
  output logic           busy_o,
  output logic [K:0]     recip_o
);

  localparam int CW = $clog2(K + 2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_RUN
  } state_e;

  state_e          state_q;
  logic [NW-1:0]   n_q;
  logic [NW-1:0]   rem_q;
  logic [K:0]      dvd_q;
  logic [CW-1:0]   cnt_q;
  logic [NW:0]     trial;
  logic            take;
  logic [2*FEW-1:0] sq;

  assign sq    = factor_i * factor_i;
  assign trial = {rem_q, dvd_q[K]};
  assign take  = trial >= {1'b0, n_q};

  // dividend is 2^K + n - 1 so the quotient rounds up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SQUARE;
      n_q     <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      cnt_q   <= '0;
    end else if (start_i) begin
      state_q <= ST_SQUARE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          state_q <= ST_IDLE;
        end
        ST_SQUARE: begin
          n_q     <= NW'(sq);
          state_q <= ST_INIT;
        end
        ST_INIT: begin
          dvd_q   <= {1'b1, {K{1'b0}}} + (K+1)'(n_q) - (K+1)'(1);
          rem_q   <= '0;
          cnt_q   <= CW'(K + 1);
          state_q <= ST_RUN;
        end
        ST_RUN: begin
          rem_q <= take ? NW'(trial - {1'b0, n_q}) : trial[NW-1:0];
          dvd_q <= {dvd_q[K-1:0], take};
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o  = state_q != ST_IDLE;
  assign recip_o = dvd_q;

endmodule

// File: sv/rbd_accum.sv
// ----------------------------------------------------------------------------
// rbd_accum
// column sum memory with read-modify-write and write-to-read forwarding
// ----------------------------------------------------------------------------
module rbd_accum import rbd_pkg::*; #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int SUM_W = 18
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [AW-1:0]      rd_addr_i,
  input  pix_t               pix_i,
  input  blk_ctl_t           ctl_i,
  output logic [3*SUM_W-1:0] sum_o,
  output out_ctl_t           sum_ctl_o
);

  localparam int DW = 3 * SUM_W;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  logic          s1_valid_q;
  logic [AW-1:0] s1_addr_q;
  pix_t          s1_pix_q;
  blk_ctl_t      s1_ctl_q;

  logic          lw_valid_q;
  logic [AW-1:0] lw_addr_q;
  logic [DW-1:0] lw_data_q;

  logic [DW-1:0]    base;
  logic [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0] sum_g;
  logic [SUM_W-1:0] sum_b;
  logic [DW-1:0]    new_sum;
  logic [DW-1:0]    sum_q;
  out_ctl_t         sum_ctl_q;

  // the write of the previous beat lands on the same edge as this read
  always_comb begin
    if (s1_ctl_q.first) begin
      base = '0;
    end else if (lw_valid_q && (lw_addr_q == s1_addr_q)) begin
      base = lw_data_q;
    end else begin
      base = rdata_q;
    end
  end

  assign sum_r   = base[DW-1 -: SUM_W] + SUM_W'(s1_pix_q.r);
  assign sum_g   = base[2*SUM_W-1 -: SUM_W] + SUM_W'(s1_pix_q.g);
  assign sum_b   = base[SUM_W-1:0] + SUM_W'(s1_pix_q.b);
  assign new_sum = {sum_r, sum_g, sum_b};

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr_i];
    end
    if (s1_valid_q) begin
      mem[s1_addr_q] <= new_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
      sum_ctl_q  <= '0;
    end else begin
      s1_valid_q      <= rd_en_i;
      lw_valid_q      <= s1_valid_q;
      sum_ctl_q.valid <= s1_valid_q && s1_ctl_q.emit;
      sum_ctl_q.last  <= s1_ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      s1_addr_q <= rd_addr_i;
      s1_pix_q  <= pix_i;
      s1_ctl_q  <= ctl_i;
    end
    if (s1_valid_q) begin
      lw_addr_q <= s1_addr_q;
      lw_data_q <= new_sum;
      sum_q     <= new_sum;
    end
  end

  assign sum_o     = sum_q;
  assign sum_ctl_o = sum_ctl_q;

endmodule

// File: sv/rbd_avg.sv
// ----------------------------------------------------------------------------
// rbd_avg
// reciprocal multiply of the block sums and output queue
// ----------------------------------------------------------------------------
module rbd_avg import rbd_pkg::*; #(
  parameter int SUM_W = 18,
  parameter int K     = 29
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [3*SUM_W-1:0] sum_i,
  input  out_ctl_t           sum_ctl_i,
  input  logic [K:0]         recip_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output avg_pix_t           avg_o
);

  localparam int PW = SUM_W + K + 1;

  logic [PW-1:0] prod_r;
  logic [PW-1:0] prod_g;
  logic [PW-1:0] prod_b;
  avg_pix_t      avg_new;

  avg_pix_t      q_mem [QDEPTH];
  logic [QPW-1:0] wr_ptr_q;
  logic [QPW-1:0] rd_ptr_q;
  logic [QCW-1:0] cnt_q;
  logic          push;
  logic          pop;

  assign prod_r = PW'(sum_i[3*SUM_W-1 -: SUM_W]) * PW'(recip_i);
  assign prod_g = PW'(sum_i[2*SUM_W-1 -: SUM_W]) * PW'(recip_i);
  assign prod_b = PW'(sum_i[SUM_W-1:0]) * PW'(recip_i);

  assign avg_new.r    = prod_r[K +: PIX_W];
  assign avg_new.g    = prod_g[K +: PIX_W];
  assign avg_new.b    = prod_b[K +: PIX_W];
  assign avg_new.last = sum_ctl_i.last;

  assign push = sum_ctl_i.valid;
  assign pop  = (cnt_q != '0) && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= avg_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPW'(1);
      end
      cnt_q <= cnt_q + QCW'(push) - QCW'(pop);
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign avg_o       = q_mem[rd_ptr_q];

endmodule

// File: sv/rgb_box_downsampler.sv
// ----------------------------------------------------------------------------
// rgb_box_downsampler
// integer-factor box filter downsampler for raster rgb pixel streams
// ----------------------------------------------------------------------------
// Takes one pixel per cycle while in_stall_o is low: the column sum memory is
// read on the accept edge and written back on the next edge, with the previous
// write forwarded, so back-to-back pixels of one block need no bubble. An
// output beat becomes valid once the completed block sum has passed the
// accumulator stage and sum registers and been written into the output queue.
// The input also stalls while four output beats are pending, so a stalled
// output side throttles the source. After reset and after each write of
// shrink_factor the input stalls while the bit-serial reciprocal unit
// computes ceil(2^K / f^2); averaging is then a multiply.
// The column sum memory needs no clearing pass: every entry is overwritten
// by the first pixel of its block. Any register write restarts the image.
module rgb_box_downsampler import rbd_pkg::*; #(
  parameter int MAX_WIDTH  = 8192,
  parameter int MAX_FACTOR = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIX_W-1:0]      red_in_i,
  input  logic [PIX_W-1:0]      green_in_i,
  input  logic [PIX_W-1:0]      blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      red_avg_o,
  output logic [PIX_W-1:0]      green_avg_o,
  output logic [PIX_W-1:0]      blue_avg_o,
  output logic                  last_of_image_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int F_MAX_EFF = (MAX_FACTOR < (1 << FACTOR_W) - 1) ? MAX_FACTOR
                                                                 : (1 << FACTOR_W) - 1;
  localparam int FEW   = $clog2(F_MAX_EFF + 1);
  localparam int CBW   = $clog2(F_MAX_EFF);
  localparam int NW    = $clog2(F_MAX_EFF * F_MAX_EFF + 1);
  localparam int SUM_W = PIX_W + $clog2(F_MAX_EFF * F_MAX_EFF);
  localparam int K     = SUM_W + NW;
  localparam int W_EFF_MAX = (MAX_WIDTH < (1 << WIDTH_FIELD_W) - 1) ? MAX_WIDTH
                                                                    : (1 << WIDTH_FIELD_W) - 1;
  localparam int WEW = $clog2(W_EFF_MAX + 1);
  localparam int SCW = $clog2(W_EFF_MAX);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = ((WEW > FEW) ? WEW : FEW) + 2;
  localparam int HRW = HEIGHT_W + 2;

  // configuration
  logic [WIDTH_FIELD_W-1:0] width_q;
  logic [HEIGHT_W-1:0]      height_q;
  logic [FACTOR_W-1:0]      factor_q;
  logic                     cfg_we;
  logic                     recip_start;

  logic [WEW-1:0]      w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [FEW-1:0]      f_eff;

  // position in the source image
  logic [SCW-1:0]      src_col_q, src_col_d;
  logic [CBW-1:0]      cib_q, cib_d;
  logic [AW-1:0]       ocol_q, ocol_d;
  logic [SCW-1:0]      blk_col_q, blk_col_d;
  logic [HEIGHT_W-1:0] src_row_q, src_row_d;
  logic [CBW-1:0]      rib_q, rib_d;
  logic [HEIGHT_W-1:0] blk_row_q, blk_row_d;

  logic        accept;
  logic        col_ok, row_ok, col_last, row_last;
  logic        col_wrap, row_wrap, cib_wrap, rib_wrap;
  logic        rd_en;
  blk_ctl_t    ctl;
  pix_t        pix;

  logic           recip_busy;
  logic [K:0]     recip;
  logic [3*SUM_W-1:0] sum;
  out_ctl_t       sum_ctl;
  avg_pix_t       avg;

  logic [QCW-1:0] pend_q;
  logic           pop;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign recip_start = cfg_we && (cfg_idx_e'(cfg_index_i) == CFG_FACTOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      factor_q <= FACTOR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i[WIDTH_FIELD_W-1:0];
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        CFG_FACTOR: factor_q <= cfg_data_i[FACTOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // zero reads as one, oversize saturates
  always_comb begin
    if (width_q == '0) begin
      w_eff = WEW'(1);
    end else if (width_q > WIDTH_FIELD_W'(W_EFF_MAX)) begin
      w_eff = WEW'(W_EFF_MAX);
    end else begin
      w_eff = WEW'(width_q);
    end
    h_eff = (height_q == '0) ? HEIGHT_W'(1) : height_q;
    if (factor_q == '0) begin
      f_eff = FEW'(1);
    end else if (factor_q > FACTOR_W'(F_MAX_EFF)) begin
      f_eff = FEW'(F_MAX_EFF);
    end else begin
      f_eff = FEW'(factor_q);
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  // block fits and is the last one, from the block origin instead of w / f
  assign col_ok   = RW'(blk_col_q) + RW'(f_eff) <= RW'(w_eff);
  assign col_last = RW'(blk_col_q) + RW'({f_eff, 1'b0}) > RW'(w_eff);
  assign row_ok   = HRW'(blk_row_q) + HRW'(f_eff) <= HRW'(h_eff);
  assign row_last = HRW'(blk_row_q) + HRW'({f_eff, 1'b0}) > HRW'(h_eff);

  assign col_wrap = WEW'(src_col_q) + WEW'(1) >= w_eff;
  assign row_wrap = {1'b0, src_row_q} + (HEIGHT_W+1)'(1) >= {1'b0, h_eff};
  assign cib_wrap = FEW'(cib_q) + FEW'(1) >= f_eff;
  assign rib_wrap = FEW'(rib_q) + FEW'(1) >= f_eff;

  assign ctl.first = (cib_q == '0) && (rib_q == '0);
  assign ctl.emit  = (FEW'(cib_q) + FEW'(1) == f_eff) && (FEW'(rib_q) + FEW'(1) == f_eff);
  assign ctl.last  = col_last && row_last;
  assign rd_en     = accept && col_ok && row_ok;

  assign pix.r = red_in_i;
  assign pix.g = green_in_i;
  assign pix.b = blue_in_i;

  always_comb begin
    src_col_d = src_col_q;
    cib_d     = cib_q;
    ocol_d    = ocol_q;
    blk_col_d = blk_col_q;
    src_row_d = src_row_q;
    rib_d     = rib_q;
    blk_row_d = blk_row_q;
    if (col_wrap) begin
      src_col_d = '0;
      cib_d     = '0;
      ocol_d    = '0;
      blk_col_d = '0;
      if (row_wrap) begin
        src_row_d = '0;
        rib_d     = '0;
        blk_row_d = '0;
      end else begin
        src_row_d = src_row_q + HEIGHT_W'(1);
        if (rib_wrap) begin
          rib_d     = '0;
          blk_row_d = HEIGHT_W'(HRW'(blk_row_q) + HRW'(f_eff));
        end else begin
          rib_d = rib_q + CBW'(1);
        end
      end
    end else begin
      src_col_d = src_col_q + SCW'(1);
      if (cib_wrap) begin
        cib_d     = '0;
        ocol_d    = ocol_q + AW'(1);
        blk_col_d = SCW'(RW'(blk_col_q) + RW'(f_eff));
      end else begin
        cib_d = cib_q + CBW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      cib_q     <= '0;
      ocol_q    <= '0;
      blk_col_q <= '0;
      src_row_q <= '0;
      rib_q     <= '0;
      blk_row_q <= '0;
    end else if (cfg_we) begin
      src_col_q <= '0;
      cib_q     <= '0;
      ocol_q    <= '0;
      blk_col_q <= '0;
      src_row_q <= '0;
      rib_q     <= '0;
      blk_row_q <= '0;
    end else if (accept) begin
      src_col_q <= src_col_d;
      cib_q     <= cib_d;
      ocol_q    <= ocol_d;
      blk_col_q <= blk_col_d;
      src_row_q <= src_row_d;
      rib_q     <= rib_d;
      blk_row_q <= blk_row_d;
    end
  end

  // outputs in flight or queued; the queue never overflows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + QCW'(rd_en && ctl.emit) - QCW'(pop);
    end
  end

  assign in_stall_o = recip_busy || (pend_q == QCW'(QDEPTH));

  rbd_recip #(
    .FEW (FEW),
    .NW  (NW),
    .K   (K)
  ) u_recip (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (recip_start),
    .factor_i (f_eff),
    .busy_o   (recip_busy),
    .recip_o  (recip)
  );

  rbd_accum #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .SUM_W (SUM_W)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (ocol_q),
    .pix_i     (pix),
    .ctl_i     (ctl),
    .sum_o     (sum),
    .sum_ctl_o (sum_ctl)
  );

  rbd_avg #(
    .SUM_W (SUM_W),
    .K     (K)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_i       (sum),
    .sum_ctl_i   (sum_ctl),
    .recip_i     (recip),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .avg_o       (avg)
  );

  assign red_avg_o       = avg.r;
  assign green_avg_o     = avg.g;
  assign blue_avg_o      = avg.b;
  assign last_of_image_o = avg.last;

`include "rgb_box_downsampler_assert.svh"

  `RBD_ASSERT_IMPL(a_out_has_credit, out_valid_o, pend_q != '0, "output beat without credit")
  `RBD_ASSERT_ALWAYS(a_block_origin,
    RW'(blk_col_q) + RW'(cib_q) == RW'(src_col_q), "block origin lost")
  `RBD_ASSERT_ALWAYS(a_pos_range,
    (WEW'(src_col_q) < w_eff) && (FEW'(cib_q) < f_eff) && (FEW'(rib_q) < f_eff) &&
    (src_row_q < h_eff), "position out of range")

endmodule

// File: sim/rgb_box_downsampler_tb.sv
// ----------------------------------------------------------------------------
// rgb_box_downsampler_tb
// self-checking bench for the integer-factor box filter downsampler
// ----------------------------------------------------------------------------
// Pixels are streamed in raster order with random gaps, and the output is
// stalled at random. A behavioral box-average predictor runs on every
// accepted input beat and queues the expected averaged pixel. Each output
// beat is compared field by field against the oldest queued pixel.
// Geometry registers are rewritten only once the output side has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_box_downsampler_tb;
  import rbd_pkg::*;

  localparam int MAX_COLS = 8192;
  localparam int MAX_SIDE = 32;
  localparam int BIG_SIDE = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  // index past the register list: restarts the image, changes nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      red_in_i = '0;
  logic [PIX_W-1:0]      green_in_i = '0;
  logic [PIX_W-1:0]      blue_in_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PIX_W-1:0]      red_avg_o;
  logic [PIX_W-1:0]      green_avg_o;
  logic [PIX_W-1:0]      blue_avg_o;
  logic                  last_of_image_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor state
  logic [WIDTH_FIELD_W-1:0] cur_width = WIDTH_RST;
  logic [HEIGHT_W-1:0]      cur_height = HEIGHT_RST;
  logic [FACTOR_W-1:0]      cur_factor = FACTOR_RST;
  logic [17:0]              sum_r [MAX_COLS];
  logic [17:0]              sum_g [MAX_COLS];
  logic [17:0]              sum_b [MAX_COLS];
  logic [12:0]              src_col = '0;
  logic [15:0]              src_row = '0;
  logic [4:0]               col_in_blk = '0;
  logic [4:0]               row_in_blk = '0;
  logic [12:0]              out_col = '0;

  avg_pix_t    pending_avgs [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;

  rgb_box_downsampler #(
    .MAX_WIDTH  (MAX_COLS),
    .MAX_FACTOR (MAX_SIDE)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_avg_o       (red_avg_o),
    .green_avg_o     (green_avg_o),
    .blue_avg_o      (blue_avg_o),
    .last_of_image_o (last_of_image_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // box average of one accepted source pixel, queues an output when its block closes
  function automatic void accumulate_pixel(input pix_t px);
    int unsigned w, h, f, out_w, out_h, n;
    avg_pix_t res;
    w = cur_width;
    h = cur_height;
    f = cur_factor;
    if (w == 0) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (h == 0) h = 1;
    if (f == 0) f = 1;
    if (f > MAX_SIDE) f = MAX_SIDE;
    out_w = w / f;
    out_h = h / f;
    if (src_col < out_w * f && src_row < out_h * f && out_col < out_w) begin
      if (row_in_blk == 0 && col_in_blk == 0) begin
        sum_r[out_col] = px.r;
        sum_g[out_col] = px.g;
        sum_b[out_col] = px.b;
      end else begin
        sum_r[out_col] += px.r;
        sum_g[out_col] += px.g;
        sum_b[out_col] += px.b;
      end
      if (row_in_blk + 1 == f && col_in_blk + 1 == f) begin
        n = f * f;
        res.r = 8'(sum_r[out_col] / n);
        res.g = 8'(sum_g[out_col] / n);
        res.b = 8'(sum_b[out_col] / n);
        res.last = (src_row / f + 1 == out_h) && (out_col + 1 == out_w);
        pending_avgs.push_back(res);
      end
    end
    if (src_col + 1 >= w) begin
      src_col = '0;
      col_in_blk = '0;
      out_col = '0;
      if (src_row + 1 >= h) begin
        src_row = '0;
        row_in_blk = '0;
      end else begin
        src_row++;
        row_in_blk = (row_in_blk + 1 >= f) ? 5'd0 : row_in_blk + 5'd1;
      end
    end else begin
      src_col++;
      if (col_in_blk + 1 >= f) begin
        col_in_blk = '0;
        out_col++;
      end else begin
        col_in_blk++;
      end
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    avg_pix_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_avgs.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual r %0d g %0d b %0d last %0d",
                 $time, red_avg_o, green_avg_o, blue_avg_o, last_of_image_o);
        fail_count++;
      end else begin
        want = pending_avgs.pop_front();
        check_field("red_avg", want.r, red_avg_o);
        check_field("green_avg", want.g, green_avg_o);
        check_field("blue_avg", want.b, blue_avg_o);
        check_field("last_of_image", 8'(want.last), 8'(last_of_image_o));
      end
    end
  end

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pix_t px;
    px = '{r: r, g: g, b: b};
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accumulate_pixel(px);
  endtask

  // drop valid, wait for every queued pixel, then let the pipeline settle
  task automatic drain_results(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WIDTH:  cur_width = data[WIDTH_FIELD_W-1:0];
      CFG_HEIGHT: cur_height = data[HEIGHT_W-1:0];
      CFG_FACTOR: cur_factor = data[FACTOR_W-1:0];
      default: ;
    endcase
    // any write restarts the image
    src_col = '0;
    src_row = '0;
    col_in_blk = '0;
    row_in_blk = '0;
    out_col = '0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_image(input int unsigned w, input int unsigned h, input int unsigned f);
    drain_results(SETTLE_CYCLES);
    write_reg(CFG_WIDTH, 16'(w));
    write_reg(CFG_HEIGHT, 16'(h));
    write_reg(CFG_FACTOR, 16'(f));
  endtask

  // reset geometry is one row with factor two, so nothing comes out
  task automatic test_reset_defaults();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h5A, 8'hA5, 8'h3C);
  endtask

  task automatic test_pass_through();
    set_image(2, 2, 1);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h55, 8'hAA, 8'h0F);
    send_pixel(8'hAA, 8'h55, 8'hF0);
  endtask

  // zero registers act as one
  task automatic test_zero_config();
    set_image(0, 0, 0);
    send_pixel(8'h12, 8'h34, 8'h56);
    send_pixel(8'hFE, 8'h01, 8'h80);
  endtask

  // truncating average plus dropped right column and bottom row
  task automatic test_block_average();
    set_image(3, 3, 2);
    for (int i = 0; i < 9; i++) send_pixel(8'(i * 37 + 1), 8'(255 - i * 29), 8'(i * 3 + 2));
  endtask

  task automatic test_restart_on_write();
    set_image(2, 2, 2);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    drain_results(SETTLE_CYCLES);
    write_reg(CFG_UNUSED, 16'h0000);
    send_pixel(8'h01, 8'h02, 8'h03);
    send_pixel(8'h04, 8'h05, 8'h06);
    send_pixel(8'h07, 8'h08, 8'h09);
    send_pixel(8'h0A, 8'h0B, 8'h0D);
  endtask

  // block wider than the image: counted and wrapped, no output
  task automatic test_factor_too_large();
    set_image(2, 2, 3);
    for (int i = 0; i < 4; i++) send_pixel(8'(i * 60), 8'(i * 70), 8'(i * 80));
  endtask

  // all-ones data: width and factor saturate, height takes its largest value
  task automatic test_saturation();
    set_image(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(8'hFF, 8'h00, 8'h7F);
    send_pixel(8'h80, 8'hFF, 8'h01);
    send_pixel(8'h33, 8'hCC, 8'hFF);
  endtask

  // large block with full-scale pixels drives the sums high
  task automatic test_max_block();
    idle_pct = 29;
    stall_pct = 29;
    set_image(BIG_SIDE, BIG_SIDE, BIG_SIDE);
    repeat (BIG_SIDE * BIG_SIDE) send_pixel(8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_random_images();
    int unsigned f, w, h, n, images, sent, roll;
    bit extreme, paused;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 74; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 74; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      sent = 0;
      paused = 1'b0;
      while (sent < 70) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          f = $urandom_range(1, 3);
          w = $urandom_range(1, 3 * f + 2);
          h = $urandom_range(1, 3 * f + 2);
        end else if (roll < 95) begin
          f = $urandom_range(4, 5);
          w = $urandom_range(f - 1, 2 * f + 1);
          h = $urandom_range(f - 1, 2 * f + 1);
        end else begin
          f = $urandom_range(6, 8);
          w = $urandom_range(f - 1, f + 1);
          h = $urandom_range(f - 1, f + 1);
        end
        set_image(w, h, f);
        images = $urandom_range(1, 2);
        repeat (images) begin
          n = w * h;
          // now and then cut the image short, the next write restarts it
          if ($urandom_range(9) == 0) n = $urandom_range(1, n);
          extreme = ($urandom_range(7) == 0);
          for (int i = 0; i < n; i++) begin
            if (!paused && i == n / 2) begin
              drain_results(0);
              paused = 1'b1;
            end
            if (extreme)
              send_pixel(8'($urandom_range(1) * 255), 8'($urandom_range(1) * 255),
                         8'($urandom_range(1) * 255));
            else
              send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            sent++;
          end
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_pass_through();
    test_zero_config();
    test_block_average();
    test_restart_on_write();
    test_factor_too_large();
    test_saturation();
    test_max_block();
    test_random_images();
    drain_results(SETTLE_CYCLES + 2);
    if (fail_count == 0 && pending_avgs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/rbd_pkg.sv
sv/rbd_recip.sv
sv/rbd_accum.sv
sv/rbd_avg.sv
sv/rgb_box_downsampler.sv
sim/rgb_box_downsampler_tb.sv
